>>> hdl/gbs_pkg.sv
// ----------------------------------------------------------------------------
// gbs_pkg
// Shared widths, register indexes, item types and divider tag for the
// single-Gaussian background subtraction block.
// ----------------------------------------------------------------------------
package gbs_pkg;

    localparam int PIX_W      = 8;
    localparam int POS_W      = 16;      // PIXELS_PER_FRAME = 65536
    localparam int MEM_DEPTH  = 65536;
    localparam int SUM_W      = 16;
    localparam int SQ_W       = 24;
    localparam int MEAN_W     = 8;
    localparam int VAR_W      = 14;
    localparam int NF_W       = 9;
    localparam int WT_W       = 8;
    localparam int CFG_AW     = 2;
    localparam int CFG_DW     = 9;
    localparam int MAX_FRAMES = 256;
    localparam int DIV_W      = 24;
    localparam int REM_W      = 10;
    localparam int NUM_W      = 27;
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_AW    = 2;
    localparam int OQ_DEPTH   = 8;
    localparam int OQ_AW      = 3;
    localparam int INF_W      = 7;

    localparam logic [CFG_AW-1:0] CFG_FRAMES = 2'd0;
    localparam logic [CFG_AW-1:0] CFG_WEIGHT = 2'd1;

    localparam logic [NF_W-1:0]   FRAMES_RST = 9'd200;
    localparam logic [WT_W-1:0]   WEIGHT_RST = 8'd24;
    localparam logic [MEAN_W-1:0] MEAN_MAX   = 8'd255;
    localparam logic [VAR_W-1:0]  VAR_MAX    = 14'h3fff;

    typedef logic [1:0] t_mode;
    localparam t_mode MODE_TRAIN  = 2'd0;
    localparam t_mode MODE_MODEL  = 2'd1;
    localparam t_mode MODE_DETECT = 2'd2;

    typedef struct packed {
        logic [POS_W-1:0] pos;
        t_mode            mode;
        logic [PIX_W-1:0] pixel;
        logic             eof;
    } t_item;

    typedef struct packed {
        logic [NF_W-1:0] frames;   // already clamped to 1..MAX_FRAMES
        logic [WT_W-1:0] weight;
        logic            restart;
    } t_cfg;

    typedef struct packed {
        logic [POS_W-1:0]  pos;
        logic [SUM_W-1:0]  sum;
        logic [SQ_W-1:0]   sq;
        logic [MEAN_W-1:0] mean;
    } t_div_tag;

endpackage

>>> hdl/gbs_fifo.sv
// ----------------------------------------------------------------------------
// gbs_fifo
// Short request queue between the classifying front end and the back end.
// ----------------------------------------------------------------------------
module gbs_fifo import gbs_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_push,
    input  t_item i_item,
    input  logic  i_pop,
    output logic  o_full,
    output logic  o_empty,
    output t_item o_item
);

    t_item                r_mem [FIFO_DEPTH];
    logic [FIFO_AW-1:0]   r_wr;
    logic [FIFO_AW-1:0]   r_rd;
    logic [FIFO_AW:0]     r_cnt;

    assign o_full  = (r_cnt == (FIFO_AW+1)'(FIFO_DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_item  = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) r_wr <= r_wr + 1'b1;
            if (i_pop)  r_rd <= r_rd + 1'b1;
            if (i_push && !i_pop)      r_cnt <= r_cnt + 1'b1;
            else if (!i_push && i_pop) r_cnt <= r_cnt - 1'b1;
        end
    end

endmodule

>>> hdl/gbs_front.sv
// ----------------------------------------------------------------------------
// gbs_front
// Configuration registers, pixel position and frame counting; tags each
// accepted pixel as training, model build or detection.
// ----------------------------------------------------------------------------
module gbs_front import gbs_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_stall,
    input  logic [PIX_W-1:0]  i_pixel,
    input  logic              i_end_of_frame,
    input  logic              i_cfg_we,
    input  logic [CFG_AW-1:0] i_cfg_addr,
    input  logic [CFG_DW-1:0] i_cfg_data,
    input  logic              i_clearing,
    input  logic              i_q_full,
    output logic              o_push,
    output t_item             o_item,
    output t_cfg              o_cfg
);

    logic [NF_W-1:0]  r_frames;
    logic [WT_W-1:0]  r_weight;
    logic [POS_W-1:0] r_pos;
    logic [NF_W-1:0]  r_fcnt;
    logic [NF_W-1:0]  n_used;
    logic             restart;
    t_mode            mode;

    assign restart = i_cfg_we && (i_cfg_addr == CFG_FRAMES);

    always_comb begin
        if (r_frames == '0)                         n_used = NF_W'(1);
        else if (r_frames > NF_W'(MAX_FRAMES))      n_used = NF_W'(MAX_FRAMES);
        else                                        n_used = r_frames;
    end

    always_comb begin
        if (r_fcnt < n_used)       mode = MODE_TRAIN;
        else if (r_fcnt == n_used) mode = MODE_MODEL;
        else                       mode = MODE_DETECT;
    end

    assign o_stall = i_clearing || i_q_full || restart;
    assign o_push  = i_valid && !o_stall;

    assign o_item.pos   = r_pos;
    assign o_item.mode  = mode;
    assign o_item.pixel = i_pixel;
    assign o_item.eof   = i_end_of_frame;

    assign o_cfg.frames  = n_used;
    assign o_cfg.weight  = r_weight;
    assign o_cfg.restart = restart;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frames <= FRAMES_RST;
            r_weight <= WEIGHT_RST;
            r_pos    <= '0;
            r_fcnt   <= '0;
        end else begin
            if (i_cfg_we && i_cfg_addr == CFG_FRAMES) r_frames <= i_cfg_data;
            if (i_cfg_we && i_cfg_addr == CFG_WEIGHT) r_weight <= i_cfg_data[WT_W-1:0];
            if (restart) begin
                r_pos  <= '0;
                r_fcnt <= '0;
            end else if (o_push) begin
                if (i_end_of_frame) begin
                    r_pos <= '0;
                    // saturate at N+1
                    if (r_fcnt <= n_used) r_fcnt <= r_fcnt + 1'b1;
                    else                  r_fcnt <= n_used + 1'b1;
                end else begin
                    r_pos <= r_pos + 1'b1;
                end
            end
        end
    end

endmodule

>>> hdl/gbs_div.sv
// ----------------------------------------------------------------------------
// gbs_div
// Pipelined restoring divider, one quotient bit per stage, with a tag
// carried alongside.
// ----------------------------------------------------------------------------
module gbs_div import gbs_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    input  logic [DIV_W-1:0] i_dividend,
    input  logic [NF_W-1:0]  i_divisor,
    input  t_div_tag         i_tag,
    output logic             o_valid,
    output logic [DIV_W-1:0] o_quotient,
    output t_div_tag         o_tag
);

    logic             r_vld [DIV_W];
    logic [REM_W-1:0] r_rem [DIV_W];
    logic [DIV_W-1:0] r_dq  [DIV_W];
    t_div_tag         r_tag [DIV_W];

    for (genvar k = 0; k < DIV_W; k++) begin : g_stage
        logic             v_in;
        logic [REM_W-1:0] rem_in;
        logic [DIV_W-1:0] dq_in;
        t_div_tag         tag_in;
        logic [REM_W-1:0] trial;
        logic             ge;

        if (k == 0) begin : g_first
            assign v_in   = i_valid;
            assign rem_in = '0;
            assign dq_in  = i_dividend;
            assign tag_in = i_tag;
        end else begin : g_next
            assign v_in   = r_vld[k-1];
            assign rem_in = r_rem[k-1];
            assign dq_in  = r_dq[k-1];
            assign tag_in = r_tag[k-1];
        end

        // dq shifts dividend bits out at the top and quotient bits in below
        assign trial = {rem_in[REM_W-2:0], dq_in[DIV_W-1]};
        assign ge    = trial >= REM_W'(i_divisor);

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) r_vld[k] <= 1'b0;
            else          r_vld[k] <= v_in;
        end

        always_ff @(posedge i_clk) begin
            r_rem[k] <= ge ? trial - REM_W'(i_divisor) : trial;
            r_dq[k]  <= {dq_in[DIV_W-2:0], ge};
            r_tag[k] <= tag_in;
        end
    end

    assign o_valid    = r_vld[DIV_W-1];
    assign o_quotient = r_dq[DIV_W-1];
    assign o_tag      = r_tag[DIV_W-1];

endmodule

>>> hdl/gbs_back.sv
// ----------------------------------------------------------------------------
// gbs_back
// Per-pixel memories, accumulation, model build through two dividers,
// detection compare and the output queue. Also runs the sum clearing pass.
// ----------------------------------------------------------------------------
module gbs_back import gbs_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_q_empty,
    input  t_item i_q_item,
    output logic o_q_pop,
    input  t_cfg i_cfg,
    output logic o_clearing,
    output logic o_valid,
    input  logic i_stall,
    output logic o_foreground,
    output logic o_frame_done
);

    // memories
    logic [SUM_W-1:0]  m_sum  [MEM_DEPTH];
    logic [SQ_W-1:0]   m_sq   [MEM_DEPTH];
    logic [MEAN_W-1:0] m_mean [MEM_DEPTH];
    logic [VAR_W-1:0]  m_var  [MEM_DEPTH];

    logic [SUM_W-1:0]  r_sum_rd;
    logic [SQ_W-1:0]   r_sq_rd;
    logic [MEAN_W-1:0] r_mean_rd;
    logic [VAR_W-1:0]  r_var_rd;

    // clearing pass
    logic             r_clr_active;
    logic [POS_W-1:0] r_clr_addr;

    // dispatch
    logic             dispatch;
    logic             can_go;
    logic [OQ_AW:0]   r_cred;
    logic [INF_W-1:0] r_model_cnt;

    // stage 1
    logic             r_s1_valid;
    t_item            r_s1_item;
    logic             r_fw_valid;
    logic [POS_W-1:0] r_fw_addr;
    logic [SUM_W-1:0] r_fw_sum;
    logic [SQ_W-1:0]  r_fw_sq;
    logic [SUM_W-1:0] s_eff;
    logic [SQ_W-1:0]  q_eff;

    logic             wr_en;
    logic [POS_W-1:0] wr_addr;
    logic [SUM_W-1:0] wr_sum;
    logic [SQ_W-1:0]  wr_sq;

    // model path
    logic             diva_in_v;
    t_div_tag         diva_in_tag;
    logic             diva_v;
    logic [DIV_W-1:0] diva_q;
    t_div_tag         diva_tag;
    logic [MEAN_W-1:0] mean_a;

    logic                     r_m1_valid;
    t_div_tag                 r_m1_tag;
    logic [SUM_W+MEAN_W-1:0]  r_m1_ms;
    logic [2*MEAN_W-1:0]      r_m1_mm;

    logic                     r_m2_valid;
    t_div_tag                 r_m2_tag;
    logic signed [NUM_W-1:0]  r_m2_t;
    logic [NF_W+2*MEAN_W-1:0] r_m2_nmm;

    logic signed [NUM_W-1:0]  num;
    logic [DIV_W-1:0]         num_c;

    logic             divb_v;
    logic [DIV_W-1:0] divb_q;
    t_div_tag         divb_tag;
    logic [VAR_W-1:0] var_b;

    // detect path
    logic [PIX_W-1:0]       dif;
    logic [WT_W+VAR_W-1:0]  prod;
    logic                   r_d2_valid;
    logic [PIX_W-1:0]       r_d2_dif;
    logic [WT_W+VAR_W-5:0]  r_d2_th;
    logic                   r_d2_eof;

    // output queue
    logic [1:0]       r_oq [OQ_DEPTH];
    logic [OQ_AW-1:0] r_oq_wr;
    logic [OQ_AW-1:0] r_oq_rd;
    logic [OQ_AW:0]   r_oq_cnt;
    logic             oq_pop;

    // ---------------------------------------------------------------- dispatch
    always_comb begin
        can_go = 1'b1;
        if (i_q_item.mode == MODE_DETECT) begin
            // detection waits for output room and for the model writes to land
            can_go = (r_cred < (OQ_AW+1)'(OQ_DEPTH)) && (r_model_cnt == '0);
        end
    end

    assign dispatch   = !i_q_empty && !r_clr_active && can_go;
    assign o_q_pop    = dispatch;
    assign o_clearing = r_clr_active;

    always_ff @(posedge i_clk) begin
        r_sum_rd  <= m_sum[i_q_item.pos];
        r_sq_rd   <= m_sq[i_q_item.pos];
    end

    always_ff @(posedge i_clk) begin
        r_mean_rd <= m_mean[i_q_item.pos];
        r_var_rd  <= m_var[i_q_item.pos];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_active <= 1'b1;
            r_clr_addr   <= '0;
        end else if (i_cfg.restart) begin
            r_clr_active <= 1'b1;
            r_clr_addr   <= '0;
        end else if (r_clr_active) begin
            r_clr_addr <= r_clr_addr + 1'b1;
            if (r_clr_addr == POS_W'(MEM_DEPTH - 1)) r_clr_active <= 1'b0;
        end
    end

    // ---------------------------------------------------------------- stage 1
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_s1_valid <= 1'b0;
        else          r_s1_valid <= dispatch;
        r_s1_item <= i_q_item;
    end

    // forward the write that landed on the same edge as this read
    assign s_eff = (r_fw_valid && r_fw_addr == r_s1_item.pos) ? r_fw_sum : r_sum_rd;
    assign q_eff = (r_fw_valid && r_fw_addr == r_s1_item.pos) ? r_fw_sq  : r_sq_rd;

    always_comb begin
        wr_en   = 1'b0;
        wr_addr = r_s1_item.pos;
        wr_sum  = s_eff + SUM_W'(r_s1_item.pixel);
        wr_sq   = q_eff + SQ_W'(r_s1_item.pixel * r_s1_item.pixel);
        if (r_clr_active) begin
            wr_en   = 1'b1;
            wr_addr = r_clr_addr;
            wr_sum  = '0;
            wr_sq   = '0;
        end else if (r_s1_valid && r_s1_item.mode == MODE_TRAIN) begin
            wr_en = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            m_sum[wr_addr] <= wr_sum;
            m_sq[wr_addr]  <= wr_sq;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_fw_valid <= 1'b0;
        else          r_fw_valid <= wr_en;
        r_fw_addr <= wr_addr;
        r_fw_sum  <= wr_sum;
        r_fw_sq   <= wr_sq;
    end

    // ---------------------------------------------------------------- model build
    assign diva_in_v        = r_s1_valid && (r_s1_item.mode == MODE_MODEL);
    assign diva_in_tag.pos  = r_s1_item.pos;
    assign diva_in_tag.sum  = s_eff;
    assign diva_in_tag.sq   = q_eff;
    assign diva_in_tag.mean = '0;

    gbs_div u_div_mean (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (diva_in_v),
        .i_dividend (DIV_W'(s_eff)),
        .i_divisor  (i_cfg.frames),
        .i_tag      (diva_in_tag),
        .o_valid    (diva_v),
        .o_quotient (diva_q),
        .o_tag      (diva_tag)
    );

    assign mean_a = (diva_q > DIV_W'(MEAN_MAX)) ? MEAN_MAX : diva_q[MEAN_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_m1_valid <= 1'b0;
        else          r_m1_valid <= diva_v;
        r_m1_tag <= '{pos: diva_tag.pos, sum: diva_tag.sum, sq: diva_tag.sq, mean: mean_a};
        r_m1_ms  <= mean_a * diva_tag.sum;
        r_m1_mm  <= mean_a * mean_a;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_m2_valid <= 1'b0;
        else          r_m2_valid <= r_m1_valid;
        r_m2_tag <= r_m1_tag;
        r_m2_t   <= $signed(NUM_W'(r_m1_tag.sq)) - $signed(NUM_W'({r_m1_ms, 1'b0}));
        r_m2_nmm <= i_cfg.frames * r_m1_mm;
    end

    // sum of squared deviations; clamps at zero when the sums disagree
    assign num   = r_m2_t + $signed(NUM_W'(r_m2_nmm));
    assign num_c = num[NUM_W-1] ? '0 : num[DIV_W-1:0];

    gbs_div u_div_var (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (r_m2_valid),
        .i_dividend (num_c),
        .i_divisor  (i_cfg.frames),
        .i_tag      (r_m2_tag),
        .o_valid    (divb_v),
        .o_quotient (divb_q),
        .o_tag      (divb_tag)
    );

    assign var_b = (divb_q > DIV_W'(VAR_MAX)) ? VAR_MAX : divb_q[VAR_W-1:0];

    always_ff @(posedge i_clk) begin
        if (divb_v) begin
            m_mean[divb_tag.pos] <= divb_tag.mean;
            m_var[divb_tag.pos]  <= var_b;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_model_cnt <= '0;
        end else begin
            case ({dispatch && i_q_item.mode == MODE_MODEL, divb_v})
                2'b10:   r_model_cnt <= r_model_cnt + 1'b1;
                2'b01:   r_model_cnt <= r_model_cnt - 1'b1;
                default: r_model_cnt <= r_model_cnt;
            endcase
        end
    end

    // ---------------------------------------------------------------- detection
    assign dif  = (r_s1_item.pixel > r_mean_rd) ? r_s1_item.pixel - r_mean_rd
                                                : r_mean_rd - r_s1_item.pixel;
    assign prod = i_cfg.weight * r_var_rd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_d2_valid <= 1'b0;
        else          r_d2_valid <= r_s1_valid && (r_s1_item.mode == MODE_DETECT);
        r_d2_dif <= dif;
        r_d2_th  <= prod[WT_W+VAR_W-1:4];
        r_d2_eof <= r_s1_item.eof;
    end

    // ---------------------------------------------------------------- output queue
    assign oq_pop       = o_valid && !i_stall;
    assign o_valid      = (r_oq_cnt != '0);
    assign o_foreground = r_oq[r_oq_rd][1];
    assign o_frame_done = r_oq[r_oq_rd][0];

    always_ff @(posedge i_clk) begin
        if (r_d2_valid) begin
            r_oq[r_oq_wr] <= {(WT_W+VAR_W-4)'(r_d2_dif) > r_d2_th, r_d2_eof};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_oq_wr  <= '0;
            r_oq_rd  <= '0;
            r_oq_cnt <= '0;
            r_cred   <= '0;
        end else begin
            if (r_d2_valid) r_oq_wr <= r_oq_wr + 1'b1;
            if (oq_pop)     r_oq_rd <= r_oq_rd + 1'b1;
            if (r_d2_valid && !oq_pop)      r_oq_cnt <= r_oq_cnt + 1'b1;
            else if (!r_d2_valid && oq_pop) r_oq_cnt <= r_oq_cnt - 1'b1;
            // credits cover detection requests in flight plus queued results
            case ({dispatch && i_q_item.mode == MODE_DETECT, oq_pop})
                2'b10:   r_cred <= r_cred + 1'b1;
                2'b01:   r_cred <= r_cred - 1'b1;
                default: r_cred <= r_cred;
            endcase
        end
    end

endmodule

>>> hdl/gaussian_background_subtraction_top.sv
// Throughput: one pixel per cycle while nothing stalls, using a separate read and write port
//   on the per-pixel memories; the model build pipeline also takes one per cycle.
// Detection: a dispatched request passes stage 1, the r_d2 register and the output queue
//   before it shows on o_valid. The first detection request waits for the model writes.
// Reset: synchronous active low; then a clearing pass over all MEM_DEPTH sum positions
//   holds o_stall high. A background_frames write starts the same pass.
// ----------------------------------------------------------------------------
// gaussian_background_subtraction_top
// Single-Gaussian background subtraction on a grey pixel stream.
// ----------------------------------------------------------------------------
module gaussian_background_subtraction_top import gbs_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_stall,
    input  logic [PIX_W-1:0]  i_pixel,
    input  logic              i_end_of_frame,
    output logic              o_valid,
    input  logic              i_stall,
    output logic              o_foreground,
    output logic              o_frame_done,
    input  logic              i_cfg_we,
    input  logic [CFG_AW-1:0] i_cfg_addr,
    input  logic [CFG_DW-1:0] i_cfg_data
);

    logic  clearing;
    logic  q_full;
    logic  q_empty;
    logic  push;
    logic  pop;
    t_item f_item;
    t_item q_item;
    t_cfg  cfg;

    gbs_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_pixel        (i_pixel),
        .i_end_of_frame (i_end_of_frame),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_addr     (i_cfg_addr),
        .i_cfg_data     (i_cfg_data),
        .i_clearing     (clearing),
        .i_q_full       (q_full),
        .o_push         (push),
        .o_item         (f_item),
        .o_cfg          (cfg)
    );

    gbs_fifo u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_item  (f_item),
        .i_pop   (pop),
        .o_full  (q_full),
        .o_empty (q_empty),
        .o_item  (q_item)
    );

    gbs_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_q_empty    (q_empty),
        .i_q_item     (q_item),
        .o_q_pop      (pop),
        .i_cfg        (cfg),
        .o_clearing   (clearing),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_foreground (o_foreground),
        .o_frame_done (o_frame_done)
    );

endmodule

>>> hdl/gbs_checker.sv
// ----------------------------------------------------------------------------
// gbs_checker
// Port-level checks on the background subtraction top level.
// ----------------------------------------------------------------------------
module gbs_checker import gbs_pkg::*; (
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              o_stall,
    input logic              o_valid,
    input logic              i_stall,
    input logic              o_foreground,
    input logic              o_frame_done,
    input logic              i_cfg_we,
    input logic [CFG_AW-1:0] i_cfg_addr
);

    // a stalled result stays offered
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_foreground) && $stable(o_frame_done))
        else $error("result dropped while stalled");

    // no result right after reset
    a_rst_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result present after reset");

    // reset starts the clearing pass, so no request is taken
    a_rst_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> o_stall)
        else $error("request taken during clearing pass");

    // changing the frame count restarts the model and clears the sums
    a_cfg_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cfg_we && i_cfg_addr == CFG_FRAMES |=> o_stall)
        else $error("no clearing pass after frame count write");

endmodule

bind gaussian_background_subtraction_top gbs_checker u_gbs_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .o_stall      (o_stall),
    .o_valid      (o_valid),
    .i_stall      (i_stall),
    .o_foreground (o_foreground),
    .o_frame_done (o_frame_done),
    .i_cfg_we     (i_cfg_we),
    .i_cfg_addr   (i_cfg_addr)
);

>>> sim/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking regression of the background subtraction block: a predictor
// of per-position sums, mean and variance runs over short frames, with random
// request gaps, random output stalls and register writes between phases.
// ----------------------------------------------------------------------------
module testbench;
    import gbs_pkg::*;

    typedef struct packed {
        logic [PIX_W-1:0] pixel;
        logic             eof;
    } t_req;

    typedef struct packed {
        logic fg;
        logic done;
    } t_res;

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              i_valid = 1'b0;
    logic              o_stall;
    logic [PIX_W-1:0]  i_pixel = '0;
    logic              i_end_of_frame = 1'b0;
    logic              o_valid;
    logic              i_stall = 1'b0;
    logic              o_foreground;
    logic              o_frame_done;
    logic              i_cfg_we = 1'b0;
    logic [CFG_AW-1:0] i_cfg_addr = '0;
    logic [CFG_DW-1:0] i_cfg_data = '0;

    gaussian_background_subtraction_top dut (.*);

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // predictor state
    int unsigned sum_mem [MEM_DEPTH];
    int unsigned sq_mem  [MEM_DEPTH];
    int unsigned mean_mem[MEM_DEPTH];
    int unsigned var_mem [MEM_DEPTH];
    int unsigned px_pos, frame_cnt, nframes_reg, weight_reg;

    t_req pending_reqs[$];
    t_res expected_res[$];
    int   errors = 0;

    function automatic int unsigned frames_eff();
        if (nframes_reg < 1) return 1;
        if (nframes_reg > MAX_FRAMES) return MAX_FRAMES;
        return nframes_reg;
    endfunction

    function automatic void restart_model();
        for (int i = 0; i < MEM_DEPTH; i++) begin
            sum_mem[i] = 0;
            sq_mem[i] = 0;
        end
        px_pos = 0;
        frame_cnt = 0;
    endfunction

    function automatic void predict_pixel(t_req r);
        int unsigned n, p, x, dif, th;
        longint s, q, m, num;
        t_res e;
        n = frames_eff();
        p = px_pos % MEM_DEPTH;
        x = 32'(r.pixel);
        if (frame_cnt < n) begin
            sum_mem[p] += x;
            sq_mem[p] += x * x;
        end else if (frame_cnt == n) begin
            s = sum_mem[p];
            q = sq_mem[p];
            m = s / n;
            if (m > 255) m = 255;
            num = q - 2 * m * s + longint'(n) * m * m;
            if (num < 0) num = 0;
            num = num / n;
            if (num > 16383) num = 16383;
            mean_mem[p] = int'(m);
            var_mem[p] = int'(num);
        end else begin
            dif = (x > mean_mem[p]) ? x - mean_mem[p] : mean_mem[p] - x;
            th = (weight_reg * var_mem[p]) >> 4;
            e.fg = (dif > th);
            e.done = r.eof;
            expected_res = {expected_res, e};
        end
        if (r.eof) begin
            px_pos = 0;
            frame_cnt = (frame_cnt <= n) ? frame_cnt + 1 : n + 1;
        end else begin
            px_pos = (p + 1) % MEM_DEPTH;
        end
    endfunction

    function automatic int unsigned gap_len();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 50) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(4, 30);
    endfunction

    // driver
    int unsigned send_gap = 0;
    bit          hold_off = 0;
    t_req        cur_req;
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_valid && !o_stall) begin
                predict_pixel(cur_req);
                send_gap = gap_len();
            end
            if ((!i_valid || !o_stall)) begin
                if (send_gap > 0 || hold_off || pending_reqs.size() == 0) begin
                    if (send_gap > 0) send_gap--;
                    i_valid <= 1'b0;
                end else begin
                    cur_req = pending_reqs.pop_front();
                    i_valid <= 1'b1;
                    i_pixel <= cur_req.pixel;
                    i_end_of_frame <= cur_req.eof;
                end
            end
        end
    end

    // monitor
    int unsigned stall_gap = 0;
    always @(posedge i_clk) begin
        t_res exp_r;
        if (i_rst_n) begin
            if (o_valid && !i_stall) begin
                if (expected_res.size() == 0) begin
                    $error("unexpected result fg=%0b done=%0b", o_foreground, o_frame_done);
                    errors++;
                end else begin
                    exp_r = expected_res.pop_front();
                    if (o_foreground !== exp_r.fg) begin
                        $error("foreground expected %0b actual %0b", exp_r.fg, o_foreground);
                        errors++;
                    end
                    if (o_frame_done !== exp_r.done) begin
                        $error("frame_done expected %0b actual %0b", exp_r.done, o_frame_done);
                        errors++;
                    end
                end
            end
            if (stall_gap > 0) begin
                stall_gap--;
                i_stall <= 1'b1;
            end else begin
                i_stall <= 1'b0;
                stall_gap = gap_len();
            end
        end
    end

    task automatic wait_idle();
        while (pending_reqs.size() != 0 || i_valid || expected_res.size() != 0)
            @(posedge i_clk);
        repeat (20) @(posedge i_clk);
    endtask

    task automatic cfg_write(logic [CFG_AW-1:0] addr, int unsigned value);
        @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_addr <= addr;
        i_cfg_data <= value[CFG_DW-1:0];
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        if (addr == CFG_FRAMES) begin
            nframes_reg = value & 9'h1ff;
            restart_model();
        end else if (addr == CFG_WEIGHT) begin
            weight_reg = value & 8'hff;
        end
    endtask

    // one frame of len pixels; base/spread shape the content
    task automatic queue_frame(int unsigned len, int unsigned base, int unsigned spread);
        t_req r;
        int v;
        for (int i = 0; i < len; i++) begin
            v = int'(base) + $urandom_range(0, 2 * spread) - int'(spread);
            if (v < 0) v = 0;
            if (v > 255) v = 255;
            r.pixel = v[PIX_W-1:0];
            r.eof = (i == len - 1);
            pending_reqs = {pending_reqs, r};
        end
    endtask

    // training plus model frames at a fixed length, then detection frames
    task automatic queue_phase(int unsigned len, int unsigned det_frames);
        int unsigned base, spread;
        base = $urandom_range(0, 255);
        spread = $urandom_range(0, 40);
        for (int f = 0; f <= frames_eff(); f++) queue_frame(len, base, spread);
        for (int f = 0; f < det_frames; f++)
            queue_frame(len, base, $urandom_range(0, 1) ? spread : 128);
    endtask

    initial begin
        int unsigned sent;
        t_req r;
        nframes_reg = FRAMES_RST;
        weight_reg = WEIGHT_RST;
        restart_model();
        for (int i = 0; i < MEM_DEPTH; i++) begin
            mean_mem[i] = 0;
            var_mem[i] = 0;
        end
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: one background frame, extremes of the pixel
        cfg_write(CFG_FRAMES, 1);
        cfg_write(CFG_WEIGHT, 0);
        r = '{pixel: 8'd0, eof: 1'b0};   pending_reqs = {pending_reqs, r};
        r = '{pixel: 8'd255, eof: 1'b0}; pending_reqs = {pending_reqs, r};
        r = '{pixel: 8'd128, eof: 1'b1}; pending_reqs = {pending_reqs, r};
        queue_frame(3, 0, 0);            // model frame
        r = '{pixel: 8'd0, eof: 1'b0};   pending_reqs = {pending_reqs, r};
        r = '{pixel: 8'd255, eof: 1'b0}; pending_reqs = {pending_reqs, r};
        r = '{pixel: 8'd128, eof: 1'b1}; pending_reqs = {pending_reqs, r};
        // short frame leaves later positions untouched
        r = '{pixel: 8'd255, eof: 1'b1}; pending_reqs = {pending_reqs, r};
        queue_frame(3, 128, 0);
        wait_idle();

        // uneven sampling: long training frame, short model frame, frames_reg 0
        cfg_write(CFG_FRAMES, 0);
        cfg_write(CFG_WEIGHT, 255);
        queue_frame(4, 200, 55);
        queue_frame(2, 0, 0);
        queue_frame(2, 100, 100);
        wait_idle();

        // sender holds off until the pipeline drains
        cfg_write(CFG_FRAMES, 2);
        queue_phase(6, 2);
        while (pending_reqs.size() > 6) @(posedge i_clk);
        hold_off = 1;
        while (expected_res.size() != 0 || i_valid) @(posedge i_clk);
        hold_off = 0;
        queue_phase(6, 2);  // continues in detection mode
        wait_idle();

        // random phases; one uses the maximum frame count
        sent = 0;
        while (sent < 1800) begin
            if (sent == 0) begin
                cfg_write(CFG_FRAMES, 256);
                cfg_write(CFG_WEIGHT, $urandom_range(0, 255));
                queue_phase(1, 40);
                sent += 297;
            end else begin
                cfg_write(CFG_FRAMES, $urandom_range(1, 6));
                cfg_write(CFG_WEIGHT, $urandom_range(0, 1) ? $urandom_range(0, 255) : 24);
                queue_phase($urandom_range(1, 24), $urandom_range(2, 6));
                sent += pending_reqs.size();
            end
            wait_idle();
        end
        repeat (20) @(posedge i_clk);
        if (errors == 0 && expected_res.size() == 0) begin
            $display("gaussian_background_subtraction_top regression: pass");
        end else begin
            $display("gaussian_background_subtraction_top regression: fail");
        end
        $finish;
    end

    // each background_frames write costs a clearing pass over every sum position
    initial begin
        #40000000;
        $display("gaussian_background_subtraction_top regression: fail");
        $finish;
    end

endmodule

>>> gaussian_background_subtraction_top.f
hdl/gbs_pkg.sv
hdl/gbs_fifo.sv
hdl/gbs_front.sv
hdl/gbs_div.sv
hdl/gbs_back.sv
hdl/gaussian_background_subtraction_top.sv
hdl/gbs_checker.sv
sim/testbench.sv
